/* rtl/acm_pkg.sv */
// Shared types, constants and helpers for the actuator channel mixer.
package acm_pkg;

  localparam int unsigned MaxChannelsDef = 8;
  localparam int unsigned NumSetsDef     = 8;
  localparam int unsigned CmdW           = 16;
  localparam int unsigned WordW          = 16;
  localparam int unsigned AddrW          = 10;
  localparam int unsigned CfgW           = 4;

  // Table word kinds carried in the top four address bits
  localparam logic [3:0] KindRoll     = 4'd0;
  localparam logic [3:0] KindPitch    = 4'd1;
  localparam logic [3:0] KindYaw      = 4'd2;
  localparam logic [3:0] KindThrottle = 4'd3;
  localparam logic [3:0] KindMin      = 4'd4;
  localparam logic [3:0] KindMax      = 4'd5;
  localparam logic [3:0] KindCenter   = 4'd6;
  localparam logic [3:0] KindCamber   = 4'd7;
  localparam logic [3:0] KindSpecial  = 4'd8;
  localparam logic [3:0] KindLowLim   = 4'd9;
  localparam logic [3:0] KindHighLim  = 4'd10;

  // Set selector meaning no offset added
  localparam logic [2:0] SetNone = 3'd0;

  localparam logic ActMix   = 1'b0;
  localparam logic ActWrite = 1'b1;

  localparam logic signed [18:0] MixHi = 19'sd262143;
  localparam logic signed [18:0] MixLo = -19'sd262144;

  // Input tdata packing from bit 0: action .. table_word
  typedef struct packed {
    logic [15:0]        table_word;
    logic [9:0]         table_address;
    logic signed [15:0] special_amount;
    logic [2:0]         special_set;
    logic signed [15:0] camber_amount;
    logic [2:0]         camber_set;
    logic [2:0]         throw_set;
    logic signed [15:0] throttle_cmd;
    logic signed [15:0] yaw_cmd;
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] roll_cmd;
    logic               action;
  } in_item_t;

  localparam int unsigned InW     = $bits(in_item_t);
  localparam int unsigned InBytes = (InW + 7) / 8;

  // Lowest set bit of a loaded mask, or want itself when loaded
  function automatic logic [4:0] pick_set(input logic [15:0] marks, input logic [2:0] want);
    logic [4:0] r;
    r = 5'h10;
    for (int s = 15; s >= 0; s--) begin
      if (marks[s]) r = 5'(s);
    end
    if (marks[want]) r = {2'b00, want};
    return r;
  endfunction

endpackage

/* rtl/acm_tables.sv */
// Table store for the mixer: coefficient, throw, offset and limit words.
module acm_tables
  import acm_pkg::*;
#(
  parameter int unsigned MaxChannels = MaxChannelsDef,
  parameter int unsigned NumSets     = NumSetsDef,
  localparam int unsigned ChW  = (MaxChannels > 1) ? $clog2(MaxChannels) : 1,
  localparam int unsigned SetW = (NumSets > 1) ? $clog2(NumSets) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WordW-1:0] wr_word_i,
  input  logic [ChW-1:0]   rd_ch_i,
  input  logic [SetW-1:0]  rd_ts_i,
  input  logic [SetW-1:0]  rd_cs_i,
  input  logic [SetW-1:0]  rd_ss_i,
  output logic [WordW-1:0] coef_o [4],
  output logic [WordW-1:0] min_o,
  output logic [WordW-1:0] max_o,
  output logic [WordW-1:0] ctr_o,
  output logic [WordW-1:0] cam_o,
  output logic [WordW-1:0] spc_o,
  output logic [WordW-1:0] lo_o,
  output logic [WordW-1:0] hi_o,
  output logic [NumSets-1:0] marks_o [3]
);

  logic [WordW-1:0] coef_q [4][MaxChannels];
  logic [WordW-1:0] min_q [NumSets][MaxChannels];
  logic [WordW-1:0] max_q [NumSets][MaxChannels];
  logic [WordW-1:0] ctr_q [NumSets][MaxChannels];
  logic [WordW-1:0] cam_q [NumSets][MaxChannels];
  logic [WordW-1:0] spc_q [NumSets][MaxChannels];
  logic [WordW-1:0] lo_q [MaxChannels];
  logic [WordW-1:0] hi_q [MaxChannels];
  logic [NumSets-1:0] marks_q [3];

  logic [3:0] kind;
  logic [2:0] set_f, ch_f;
  logic       ch_ok, set_ok;

  assign kind   = wr_addr_i[9:6];
  assign set_f  = wr_addr_i[5:3];
  assign ch_f   = wr_addr_i[2:0];
  assign ch_ok  = 32'(ch_f) < MaxChannels;
  assign set_ok = 32'(set_f) < NumSets;

  // Store table words
  always_ff @(posedge clk_i) begin
    if (wr_i && ch_ok) begin
      case (kind)
        KindRoll, KindPitch, KindYaw, KindThrottle:
          coef_q[kind[1:0]][ChW'(ch_f)] <= wr_word_i;
        KindLowLim:  lo_q[ChW'(ch_f)] <= wr_word_i;
        KindHighLim: hi_q[ChW'(ch_f)] <= wr_word_i;
        KindMin:     if (set_ok) min_q[SetW'(set_f)][ChW'(ch_f)] <= wr_word_i;
        KindMax:     if (set_ok) max_q[SetW'(set_f)][ChW'(ch_f)] <= wr_word_i;
        KindCenter:  if (set_ok) ctr_q[SetW'(set_f)][ChW'(ch_f)] <= wr_word_i;
        KindCamber:  if (set_ok) cam_q[SetW'(set_f)][ChW'(ch_f)] <= wr_word_i;
        KindSpecial: if (set_ok) spc_q[SetW'(set_f)][ChW'(ch_f)] <= wr_word_i;
        default: ;
      endcase
    end
  end

  // Mark loaded sets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) marks_q[k] <= '0;
    end else if (wr_i && ch_ok && set_ok) begin
      case (kind)
        KindMin, KindMax, KindCenter: marks_q[0][SetW'(set_f)] <= 1'b1;
        KindCamber:  marks_q[1][SetW'(set_f)] <= 1'b1;
        KindSpecial: marks_q[2][SetW'(set_f)] <= 1'b1;
        default: ;
      endcase
    end
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) coef_o[k] <= coef_q[k][rd_ch_i];
    min_o <= min_q[rd_ts_i][rd_ch_i];
    max_o <= max_q[rd_ts_i][rd_ch_i];
    ctr_o <= ctr_q[rd_ts_i][rd_ch_i];
    cam_o <= cam_q[rd_cs_i][rd_ch_i];
    spc_o <= spc_q[rd_ss_i][rd_ch_i];
    lo_o  <= lo_q[rd_ch_i];
    hi_o  <= hi_q[rd_ch_i];
  end

  assign marks_o = marks_q;

endmodule

/* rtl/acm_datapath.sv */
// Channel pipeline: dot product, throw scaling, offsets, clamp and rounding.
module acm_datapath
  import acm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               vld_i,
  input  logic [2:0]         ch_i,
  input  logic               last_i,
  input  logic               ts_ok_i,
  input  logic               cs_ok_i,
  input  logic               ss_ok_i,
  input  logic signed [15:0] cmd_i [4],
  input  logic signed [15:0] cam_amt_i,
  input  logic signed [15:0] spc_amt_i,
  input  logic [WordW-1:0]   coef_i [4],
  input  logic [WordW-1:0]   min_i,
  input  logic [WordW-1:0]   max_i,
  input  logic [WordW-1:0]   ctr_i,
  input  logic [WordW-1:0]   cam_i,
  input  logic [WordW-1:0]   spc_i,
  input  logic [WordW-1:0]   lo_i,
  input  logic [WordW-1:0]   hi_i,
  output logic               vld_o,
  output logic [2:0]         ch_o,
  output logic               last_o,
  output logic [15:0]        pulse_o
);

  typedef struct packed {
    logic       last;
    logic [2:0] ch;
  } tag_t;

  // Valid and tag bits per stage
  logic [3:0] v_q;
  tag_t       tag_q [4];

  // Stage 1: four products and two offset products
  logic signed [31:0] p_q [4];
  logic signed [31:0] cp_q, sp_q;
  logic [15:0] min1_q, max1_q, ctr1_q, lo1_q, hi1_q;
  logic        ts1_q;
  // Stage 2: sum, floor, saturate, span select; offset sum
  logic signed [18:0] mix2_q;
  logic signed [32:0] off2_q;
  logic [15:0] ctr2_q, lo2_q, hi2_q;
  logic signed [16:0] span2_q;
  logic        ts2_q;
  // Stage 3: throw scaling, centre and offset add
  logic signed [36:0] acc3_q;
  logic [15:0] lo3_q, hi3_q;
  // Stage 4: clamp and round
  logic [15:0] pulse4_q;

  logic signed [33:0] dot;
  logic signed [21:0] fl;
  logic signed [18:0] mix_d;
  logic signed [16:0] span_d;
  logic signed [36:0] acc_c, lo_c, hi_c;
  logic signed [36:0] rnd;

  always_comb begin
    dot = 34'(p_q[0]) + 34'(p_q[1]) + 34'(p_q[2]) + 34'(p_q[3]);
    fl  = 22'(dot >>> 12);
    if (fl > 22'(MixHi)) mix_d = MixHi;
    else if (fl < 22'(MixLo)) mix_d = MixLo;
    else mix_d = 19'(fl);
    if (fl[21]) span_d = $signed({1'b0, ctr1_q}) - $signed({1'b0, min1_q});
    else        span_d = $signed({1'b0, max1_q}) - $signed({1'b0, ctr1_q});
    lo_c = 37'($signed({1'b0, lo3_q, 15'd0}));
    hi_c = 37'($signed({1'b0, hi3_q, 15'd0}));
    acc_c = acc3_q;
    if (acc_c < lo_c) acc_c = lo_c;
    if (acc_c > hi_c) acc_c = hi_c;
    rnd = acc_c + 37'sd16384;
  end

  // Advance valid and tag bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], vld_i};
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q[0] <= '{last: last_i, ch: ch_i};
      for (int k = 1; k < 4; k++) tag_q[k] <= tag_q[k-1];
      for (int k = 0; k < 4; k++) p_q[k] <= $signed(coef_i[k]) * cmd_i[k];
      cp_q   <= cs_ok_i ? $signed(cam_i) * cam_amt_i : 32'sd0;
      sp_q   <= ss_ok_i ? $signed(spc_i) * spc_amt_i : 32'sd0;
      min1_q <= min_i;
      max1_q <= max_i;
      ctr1_q <= ctr_i;
      lo1_q  <= lo_i;
      hi1_q  <= hi_i;
      ts1_q  <= ts_ok_i;
      mix2_q  <= mix_d;
      span2_q <= span_d;
      off2_q  <= 33'(cp_q) + 33'(sp_q);
      ctr2_q  <= ctr1_q;
      lo2_q   <= lo1_q;
      hi2_q   <= hi1_q;
      ts2_q   <= ts1_q;
      acc3_q  <= (ts2_q ? (37'(mix2_q) * 37'(span2_q)
                           + 37'($signed({1'b0, ctr2_q, 15'd0})))
                        : 37'sd0) + 37'(off2_q);
      lo3_q   <= lo2_q;
      hi3_q   <= hi2_q;
      pulse4_q <= rnd[30:15];
    end
  end

  assign vld_o   = v_q[3];
  assign ch_o    = tag_q[3].ch;
  assign last_o  = tag_q[3].last;
  assign pulse_o = pulse4_q;

endmodule

/* rtl/actuator_channel_mixer.sv */
// Top level of the actuator channel mixer: sequencer, tables, pipeline, output skid.
// Throughput: one channel per cycle while not stalled (into a five-stage pipeline; the next
//   transfer is taken the cycle after the last channel); a write does not busy the sequencer.
// The pipeline stalls as a whole when the output register is full and not taken.
// Reset (rst_ni low, asynchronous) clears valid bits, set marks and sets channel count 8.
module actuator_channel_mixer
  import acm_pkg::*;
#(
  parameter int unsigned MaxChannels = MaxChannelsDef,
  parameter int unsigned NumSets     = NumSetsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // action, roll, pitch, yaw, throttle, throw_set, camber_set, camber_amount,
  // special_set, special_amount, table_address, table_word
  input  logic [InBytes*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // channel, pulse
  output logic [23:0]          m_axis_tdata,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CfgW-1:0]      cfg_wdata_i
);

  localparam int unsigned ChW  = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned SetW = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int unsigned Lim  = (MaxChannels < 8) ? MaxChannels : 8;

  in_item_t   in_item;
  assign in_item = in_item_t'(s_axis_tdata[InW-1:0]);

  logic [CfgW-1:0] cnt_q;
  logic            busy_q;
  logic [3:0]      ch_q, n_q;
  in_item_t        item_q;
  logic            ts_ok_q, cs_ok_q, ss_ok_q;
  logic [SetW-1:0] ts_q, cs_q, ss_q;
  logic            adv;
  logic [3:0]      n_d;
  logic [NumSets-1:0] marks [3];
  logic [4:0]      pts, pcs, pss;
  logic            wr;

  // Output skid register
  logic        ov_q;
  logic [2:0]  och_q;
  logic [15:0] opl_q;
  logic        olast_q;
  logic        dv, dlast;
  logic [2:0]  dch;
  logic [15:0] dpl;

  // Table read stage valid
  logic        rv_q, rlast_q;
  logic [2:0]  rch_q;

  logic [WordW-1:0] coef [4];
  logic [WordW-1:0] mn, mx, ct, cm, sp, lo, hi;
  logic signed [15:0] cmd [4];

  assign adv = !ov_q || m_axis_tready;
  assign s_axis_tready = !busy_q && adv;
  assign wr = s_axis_tvalid && s_axis_tready && in_item.action == ActWrite;

  always_comb begin
    n_d = (cnt_q > 4'(Lim)) ? 4'(Lim) : cnt_q;
    pts = pick_set(16'(marks[0]), in_item.throw_set);
    pcs = pick_set(16'(marks[1]), in_item.camber_set);
    pss = pick_set(16'(marks[2]), in_item.special_set);
    cmd[0] = item_q.roll_cmd;
    cmd[1] = item_q.pitch_cmd;
    cmd[2] = item_q.yaw_cmd;
    cmd[3] = item_q.throttle_cmd;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 4'd8;
    else if (cfg_we_i) cnt_q <= cfg_wdata_i;
  end

  // Channel sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ch_q   <= '0;
      n_q    <= '0;
    end else if (adv) begin
      if (!busy_q) begin
        if (s_axis_tvalid && in_item.action == ActMix && n_d != 4'd0) begin
          busy_q <= 1'b1;
          ch_q   <= '0;
          n_q    <= n_d;
        end
      end else if (ch_q + 4'd1 == n_q) begin
        busy_q <= 1'b0;
      end else begin
        ch_q <= ch_q + 4'd1;
      end
    end
  end

  // Latch each accepted item and its resolved sets
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q  <= in_item;
      ts_ok_q <= !pts[4];
      cs_ok_q <= !pcs[4] && in_item.camber_set != SetNone;
      ss_ok_q <= !pss[4] && in_item.special_set != SetNone;
      ts_q    <= SetW'(pts[3:0]);
      cs_q    <= SetW'(pcs[3:0]);
      ss_q    <= SetW'(pss[3:0]);
    end
  end

  // Table read stage tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else if (adv) rv_q <= busy_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rch_q   <= ch_q[2:0];
      rlast_q <= ch_q + 4'd1 == n_q;
    end
  end

  acm_tables #(.MaxChannels(MaxChannels), .NumSets(NumSets)) u_tables (
    .clk_i, .rst_ni,
    .wr_i(wr), .wr_addr_i(in_item.table_address), .wr_word_i(in_item.table_word),
    .rd_ch_i(adv ? ChW'(ch_q) : ChW'(rch_q)),
    .rd_ts_i(ts_q), .rd_cs_i(cs_q), .rd_ss_i(ss_q),
    .coef_o(coef), .min_o(mn), .max_o(mx), .ctr_o(ct), .cam_o(cm), .spc_o(sp),
    .lo_o(lo), .hi_o(hi), .marks_o(marks)
  );

  acm_datapath u_dp (
    .clk_i, .rst_ni, .adv_i(adv),
    .vld_i(rv_q), .ch_i(rch_q), .last_i(rlast_q),
    .ts_ok_i(ts_ok_q), .cs_ok_i(cs_ok_q), .ss_ok_i(ss_ok_q),
    .cmd_i(cmd), .cam_amt_i(item_q.camber_amount), .spc_amt_i(item_q.special_amount),
    .coef_i(coef), .min_i(mn), .max_i(mx), .ctr_i(ct), .cam_i(cm), .spc_i(sp),
    .lo_i(lo), .hi_i(hi),
    .vld_o(dv), .ch_o(dch), .last_o(dlast), .pulse_o(dpl)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= dv;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      och_q   <= dch;
      opl_q   <= dpl;
      olast_q <= dlast;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {5'd0, opl_q, och_q};
  assign m_axis_tlast  = olast_q;

endmodule

/* rtl/acm_checker.sv */
// Port-level checks for the actuator channel mixer, bound to the top level.
module acm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Padding bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0)
    else $error("padding bits set");

  // No input transfer while a result is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("input taken while output stalled");

  // A run after its last transfer restarts at channel zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast ##1 m_axis_tvalid
      |-> m_axis_tdata[2:0] == 3'd0)
    else $error("run did not restart at channel zero");

endmodule

bind actuator_channel_mixer acm_checker u_acm_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

/* tb/sv/tb.sv */
// Self-checking testbench for the actuator channel mixer.
module tb;
  import acm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 20;

  typedef struct {
    logic [2:0]  channel;
    logic [15:0] pulse;
    logic        last;
  } pulse_t;

  typedef struct {
    in_item_t    item;
    logic        has_exp;
    logic [15:0] exp_pulse;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InBytes*8-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i = 1'b0;
  logic [CfgW-1:0]      cfg_wdata_i = '0;

  // Predictor state
  logic [15:0] coef_q [4][8];
  logic [15:0] tmin_q [8][8];
  logic [15:0] tmax_q [8][8];
  logic [15:0] tctr_q [8][8];
  logic [15:0] camb_q [8][8];
  logic [15:0] spec_q [8][8];
  logic [15:0] lolim_q [8];
  logic [15:0] hilim_q [8];
  logic [7:0]  marks_q [3];
  logic [3:0]  chan_count_q;

  pulse_t      pulse_exp_q[$];
  stim_row_t   stim_rows[$];
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  bit          quiet;

  always #5 clk_i = ~clk_i;

  actuator_channel_mixer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int chosen_set(input int kind, input logic [2:0] want);
    if (marks_q[kind][want]) return int'(want);
    for (int s = 0; s < 8; s++) if (marks_q[kind][s]) return s;
    return -1;
  endfunction

  function automatic void log_mismatch(input string what, input int unsigned e,
                                       input int unsigned a);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %s: expected %0d, got %0d at cycle %0d", what, e, a, cycle_cnt);
  endfunction

  // Apply one input transfer to the table copy and queue the pulses it yields
  function automatic void mixer_predict(input in_item_t it, input logic has_exp,
                                        input logic [15:0] exp_pulse);
    logic [3:0] kind;
    logic [2:0] st, ch;
    int ts, cs, ss, n;
    longint sum, mixv, acc, lo, hi, mn, mx, ce;
    pulse_t p;
    kind = it.table_address[9:6];
    st = it.table_address[5:3];
    ch = it.table_address[2:0];
    if (it.action == ActWrite) begin
      if (kind <= KindThrottle) coef_q[kind][ch] = it.table_word;
      else if (kind == KindLowLim) lolim_q[ch] = it.table_word;
      else if (kind == KindHighLim) hilim_q[ch] = it.table_word;
      else if (kind <= KindSpecial) begin
        case (kind)
          KindMin: tmin_q[st][ch] = it.table_word;
          KindMax: tmax_q[st][ch] = it.table_word;
          KindCenter: tctr_q[st][ch] = it.table_word;
          KindCamber: camb_q[st][ch] = it.table_word;
          default: spec_q[st][ch] = it.table_word;
        endcase
        if (kind <= KindCenter) marks_q[0][st] = 1'b1;
        else if (kind == KindCamber) marks_q[1][st] = 1'b1;
        else marks_q[2][st] = 1'b1;
      end
      return;
    end
    ts = chosen_set(0, it.throw_set);
    cs = (it.camber_set != SetNone) ? chosen_set(1, it.camber_set) : -1;
    ss = (it.special_set != SetNone) ? chosen_set(2, it.special_set) : -1;
    n = (chan_count_q > 8) ? 8 : chan_count_q;
    for (int c = 0; c < n; c++) begin
      sum = longint'($signed(coef_q[0][c])) * it.roll_cmd
          + longint'($signed(coef_q[1][c])) * it.pitch_cmd
          + longint'($signed(coef_q[2][c])) * it.yaw_cmd
          + longint'($signed(coef_q[3][c])) * it.throttle_cmd;
      mixv = sum >>> 12;
      if (mixv > 262143) mixv = 262143;
      if (mixv < -262144) mixv = -262144;
      acc = 0;
      if (ts >= 0) begin
        mn = tmin_q[ts][c]; mx = tmax_q[ts][c]; ce = tctr_q[ts][c];
        acc = (mixv < 0 ? mixv * (ce - mn) : mixv * (mx - ce)) + ce * 32768;
      end
      if (cs >= 0) acc += longint'($signed(camb_q[cs][c])) * it.camber_amount;
      if (ss >= 0) acc += longint'($signed(spec_q[ss][c])) * it.special_amount;
      lo = longint'(lolim_q[c]) * 32768;
      hi = longint'(hilim_q[c]) * 32768;
      if (acc < lo) acc = lo;
      if (acc > hi) acc = hi;
      p.channel = 3'(c);
      p.pulse = 16'((acc + 16384) >>> 15);
      if (has_exp && p.pulse !== exp_pulse)
        log_mismatch("directed row", exp_pulse, p.pulse);
      if (has_exp) p.pulse = exp_pulse;
      p.last = (c + 1 == n);
      pulse_exp_q.insert(pulse_exp_q.size(), p);
    end
  endfunction

  // Check each output transfer against the oldest expectation
  always @(posedge clk_i) begin
    pulse_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pulse_exp_q.size() == 0) log_mismatch("unexpected transfer", 0, 1);
      else begin
        e = pulse_exp_q.pop_front();
        if (m_axis_tdata[2:0] !== e.channel) log_mismatch("channel", e.channel, m_axis_tdata[2:0]);
        if (m_axis_tdata[18:3] !== e.pulse) log_mismatch("pulse", e.pulse, m_axis_tdata[18:3]);
        if (m_axis_tlast !== e.last) log_mismatch("last", e.last, m_axis_tlast);
      end
    end
  end

  // Receiver: random stall bursts unless told to stay ready
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && burst == 0 && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 5);
      if (burst > 0) begin
        m_axis_tready <= 1'b0; burst--;
      end else m_axis_tready <= 1'b1;
    end
  end

  // Drive one input transfer, with an optional gap burst in front
  task automatic send_item(input in_item_t it, input logic has_exp,
                           input logic [15:0] exp_pulse);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= (InBytes*8)'(it);
    do @(posedge clk_i); while (!s_axis_tready);
    mixer_predict(it, has_exp, exp_pulse);
  endtask

  // Drop the input and hold until every expected pulse has arrived
  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (pulse_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_channels(input logic [3:0] n);
    cfg_we_i <= 1'b1; cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    chan_count_q = n;
  endtask

  function automatic void add_row(input in_item_t it, input logic has_exp,
                                  input logic [15:0] exp_pulse);
    stim_row_t r;
    r.item = it; r.has_exp = has_exp; r.exp_pulse = exp_pulse;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic in_item_t table_write(input logic [3:0] kind, input logic [2:0] st,
                                           input logic [2:0] ch, input logic [15:0] w);
    in_item_t it;
    it = in_item_t'(InW'($urandom()));
    it.roll_cmd = 16'($urandom()); it.camber_amount = 16'($urandom());
    it.action = ActWrite;
    it.table_address = {kind, st, ch};
    it.table_word = w;
    return it;
  endfunction

  function automatic in_item_t mix_item(input logic [15:0] r, input logic [15:0] p,
                                        input logic [15:0] y, input logic [15:0] t);
    in_item_t it;
    it = '0;
    it.action = ActMix;
    it.roll_cmd = r; it.pitch_cmd = p; it.yaw_cmd = y; it.throttle_cmd = t;
    return it;
  endfunction

  // Load min, centre and max words of every channel of set st
  task automatic load_throw_set(input logic [2:0] st);
    for (int c = 0; c < 8; c++) begin
      send_item(table_write(KindMin, st, 3'(c), 16'($urandom_range(0, 1500))), 1'b0, 16'd0);
      send_item(table_write(KindCenter, st, 3'(c), 16'($urandom_range(1000, 2000))),
                1'b0, 16'd0);
      send_item(table_write(KindMax, st, 3'(c), 16'($urandom())), 1'b0, 16'd0);
    end
  endtask

  initial begin
    in_item_t it;
    int sent;
    for (int k = 0; k < 4; k++) for (int c = 0; c < 8; c++) coef_q[k][c] = 0;
    for (int s = 0; s < 8; s++) for (int c = 0; c < 8; c++) begin
      tmin_q[s][c] = 0; tmax_q[s][c] = 0; tctr_q[s][c] = 0;
      camb_q[s][c] = 0; spec_q[s][c] = 0;
    end
    for (int c = 0; c < 8; c++) begin
      lolim_q[c] = 0; hilim_q[c] = 0;
    end
    for (int k = 0; k < 3; k++) marks_q[k] = '0;
    chan_count_q = 8;
    quiet = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single channel, then fill the limit and coefficient words of channel 0
    set_channels(4'd1);
    add_row(table_write(KindLowLim, 3'd0, 3'd0, 16'h0000), 1'b0, 16'd0);
    add_row(table_write(KindHighLim, 3'd0, 3'd0, 16'hFFFF), 1'b0, 16'd0);
    for (int k = 0; k < 4; k++)
      add_row(table_write(4'(k), 3'd0, 3'd0, 16'h1000), 1'b0, 16'd0);
    // No set loaded yet: zero mix, all zero
    add_row(mix_item(16'd0, 16'd0, 16'd0, 16'd0), 1'b1, 16'd0);
    add_row(table_write(KindMin, 3'd2, 3'd0, 16'd1000), 1'b0, 16'd0);
    add_row(table_write(KindCenter, 3'd2, 3'd0, 16'd1500), 1'b0, 16'd0);
    add_row(table_write(KindMax, 3'd2, 3'd0, 16'd2000), 1'b0, 16'd0);
    // Centre only; unloaded set 5 falls back to set 2
    it = mix_item(16'd0, 16'd0, 16'd0, 16'd0); it.throw_set = 3'd5;
    add_row(it, 1'b1, 16'd1500);
    // Full negative commands drive the output below the low limit
    add_row(mix_item(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0, 16'd0);
    add_row(mix_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, 16'd0);
    add_row(table_write(KindCamber, 3'd3, 3'd0, 16'd100), 1'b0, 16'd0);
    add_row(table_write(KindSpecial, 3'd1, 3'd0, 16'hFF9C), 1'b0, 16'd0);
    it = mix_item(16'd0, 16'd0, 16'd0, 16'd0);
    it.throw_set = 3'd2; it.camber_set = 3'd7; it.camber_amount = 16'h7FFF;
    it.special_set = 3'd1; it.special_amount = 16'h8000;
    add_row(it, 1'b0, 16'd0);
    // Ignored write outside the tables, then low limit above high limit
    add_row(table_write(4'hF, 3'd7, 3'd7, 16'hFFFF), 1'b0, 16'd0);
    add_row(table_write(KindLowLim, 3'd0, 3'd0, 16'd3000), 1'b0, 16'd0);
    add_row(table_write(KindHighLim, 3'd0, 3'd0, 16'd2500), 1'b0, 16'd0);
    it = mix_item(16'd0, 16'd0, 16'd0, 16'd0); it.throw_set = 3'd2;
    add_row(it, 1'b1, 16'd2500);
    add_row(table_write(KindLowLim, 3'd0, 3'd0, 16'd0), 1'b0, 16'd0);
    add_row(table_write(KindHighLim, 3'd0, 3'd0, 16'hFFFF), 1'b0, 16'd0);
    foreach (stim_rows[i])
      send_item(stim_rows[i].item, stim_rows[i].has_exp, stim_rows[i].exp_pulse);

    // Load every channel so mixes over all channels read written words only
    drain_all();
    for (int c = 0; c < 8; c++) begin
      for (int k = 0; k < 4; k++)
        send_item(table_write(4'(k), 3'($urandom()), 3'(c), 16'($urandom())), 1'b0, 16'd0);
      send_item(table_write(KindLowLim, 3'($urandom()), 3'(c),
                            16'($urandom_range(0, 1200))), 1'b0, 16'd0);
      send_item(table_write(KindHighLim, 3'($urandom()), 3'(c),
                            16'($urandom_range(1800, 65535))), 1'b0, 16'd0);
      for (int s = 1; s < 8; s++) begin
        send_item(table_write(KindCamber, 3'(s), 3'(c), 16'($urandom())), 1'b0, 16'd0);
        send_item(table_write(KindSpecial, 3'(s), 3'(c), 16'($urandom())), 1'b0, 16'd0);
      end
    end
    load_throw_set(3'd0);
    load_throw_set(3'd2);
    load_throw_set(3'd6);

    // Random phases with varying channel counts, extremes included
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      drain_all();
      case (ph)
        0: set_channels(4'd8);
        1: set_channels(4'd0);
        2: set_channels(4'd15);
        3: set_channels(4'($urandom_range(2, 7)));
        default: set_channels(4'($urandom_range(1, 8)));
      endcase
      if (ph == 5) quiet = 1;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Rewrite a word; kinds beyond the tables get dropped
          it = table_write(4'($urandom_range(0, 15)), 3'($urandom()), 3'($urandom()),
                           16'($urandom()));
          if (it.table_address[9:6] == KindLowLim) it.table_word = 16'($urandom_range(0, 1200));
          if (it.table_address[9:6] == KindHighLim)
            it.table_word = 16'($urandom_range(1800, 65535));
          if (it.table_address[9:6] inside {KindMin, KindMax, KindCenter}) begin
            // Keep throw sets complete: rewrite a loaded set only
            it.table_address[5:3] = $urandom_range(0, 1) ? 3'd0 : 3'd6;
          end
        end else begin
          it = in_item_t'(InW'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()}));
          it.action = ActMix;
        end
        send_item(it, 1'b0, 16'd0);
        sent++;
        if (sent == 200) drain_all();
      end
    end
    drain_all();
    if (err_cnt == 0 && pulse_exp_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

/* actuator_channel_mixer.f */
rtl/acm_pkg.sv
rtl/acm_tables.sv
rtl/acm_datapath.sv
rtl/actuator_channel_mixer.sv
rtl/acm_checker.sv
tb/sv/tb.sv
